[rtl/lrsa_pkg.sv]
// ============================================================================
// Line raster stamp addresser package
// Shared widths, reset values, register map, segment descriptor and FSM type.
// ============================================================================
`default_nettype none

package lrsa_pkg;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int ROW_W      = 13;
    localparam int BASE_W     = 16;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 25;

    // Widest span counter that MAX_SPAN can ask for (MAX_SPAN <= 63)
    localparam int SPAN_W     = 6;
    // Signed error term: covers +/- 2 * (2^SPAN_W - 1) with margin
    localparam int ERR_W      = SPAN_W + 3;

    // Parameter defaults
    localparam int BRUSH_SIZE_DEF = 2;
    localparam int MAX_SPAN_DEF   = 63;

    // Descriptor queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [ROW_W-1:0]  ROW_WIDTH_RST   = 13'd4096;
    localparam logic [BASE_W-1:0] BASE_OFFSET_RST = 16'd0;
    localparam logic [PIX_W-1:0]  DRAW_VALUE_RST  = 8'd111;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH   = 2'd0,
        REG_BASE_OFFSET = 2'd1,
        REG_DRAW_VALUE  = 2'd2
    } reg_idx_t;

    // One classified segment as handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic                  x_move;
        logic                  x_dec;
        logic                  y_move;
        logic                  y_dec;
        logic                  xmajor;
        logic                  too_long;
        logic [SPAN_W-1:0]     major;
        logic [SPAN_W-1:0]     minor;
    } seg_desc_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

[rtl/line_raster_stamp_addresser_top.sv]
// ============================================================================
// Line raster stamp addresser
// Rasterizes line segments and emits one stamp address per line point.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  start_x, start_y, end_x, end_y
// out       output     out_valid/out_stall  point_x, point_y, stamp_address,
//                                           pixel_value, at_edge, status, last
// cfg       input      APB write (psel..)   row_width, base_offset, draw_value
//
// A segment of major span N gives N + 1 point transfers, one per cycle unless
// the output is stalled, set by the point stepper walking the Bresenham error
// term; a segment longer than MAX_SPAN gives one error transfer. The stepper
// takes each segment from the queue in its idle state, after the last one ends.
// A point passes the stepper, stage one and the output register in order.
// Reset clears the queue, the stepper and the pipeline valids; registers
// return to row_width 4096, base_offset 0, draw_value 111.
// A stalled output freezes point stepping and the pipeline; the queue keeps taking segments
// until both entries are full, then in_stall rises.
//
`default_nettype none

module line_raster_stamp_addresser_top #(
    parameter int BRUSH_SIZE = lrsa_pkg::BRUSH_SIZE_DEF,
    parameter int MAX_SPAN   = lrsa_pkg::MAX_SPAN_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Segment input
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0]      start_x,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0]      start_y,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0]      end_x,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0]      end_y,
    // Point output
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [lrsa_pkg::COORD_BITS-1:0]           point_x,
    output logic [lrsa_pkg::COORD_BITS-1:0]           point_y,
    output logic [lrsa_pkg::ADDR_W-1:0]               stamp_address,
    output logic [lrsa_pkg::PIX_W-1:0]                pixel_value,
    output logic                                      at_edge,
    output logic                                      status,
    output logic                                      last,
    // Configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lrsa_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [lrsa_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lrsa_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int DW = lrsa_pkg::APB_DATA_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lrsa_pkg::ROW_W-1:0]  row_width_reg;
    logic [lrsa_pkg::BASE_W-1:0] base_offset_reg;
    logic [lrsa_pkg::PIX_W-1:0]  draw_value_reg;
    logic                        cfg_write;
    lrsa_pkg::reg_idx_t          reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = lrsa_pkg::reg_idx_t'(paddr[lrsa_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= lrsa_pkg::ROW_WIDTH_RST;
            base_offset_reg <= lrsa_pkg::BASE_OFFSET_RST;
            draw_value_reg  <= lrsa_pkg::DRAW_VALUE_RST;
        end
        else if (cfg_write)
        begin
            // Drop writes to unmapped addresses
            unique case (reg_idx)
                lrsa_pkg::REG_ROW_WIDTH:
                    row_width_reg <= pwdata[lrsa_pkg::ROW_W-1:0];
                lrsa_pkg::REG_BASE_OFFSET:
                    base_offset_reg <= pwdata[lrsa_pkg::BASE_W-1:0];
                lrsa_pkg::REG_DRAW_VALUE:
                    draw_value_reg <= pwdata[lrsa_pkg::PIX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lrsa_pkg::REG_ROW_WIDTH:   prdata = DW'(row_width_reg);
            lrsa_pkg::REG_BASE_OFFSET: prdata = DW'(base_offset_reg);
            lrsa_pkg::REG_DRAW_VALUE:  prdata = DW'(draw_value_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: classify each segment on its transfer cycle
    // ------------------------------------------------------------------
    lrsa_pkg::seg_desc_t front_desc;
    lrsa_pkg::seg_desc_t head_desc;
    logic                q_full;
    logic                q_not_empty;
    logic                q_pop;
    logic                q_push;

    lrsa_front #(
        .MAX_SPAN (MAX_SPAN)
    ) u_front (
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .desc    (front_desc)
    );

    // Hold off new segments only while both queue entries are taken
    assign in_stall = q_full;
    assign q_push   = in_valid && !in_stall;

    lrsa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (front_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    // ------------------------------------------------------------------
    // Back: step points and build stamp addresses
    // ------------------------------------------------------------------
    lrsa_back #(
        .BRUSH_SIZE (BRUSH_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_desc        (head_desc),
        .q_pop         (q_pop),
        .row_width     (row_width_reg),
        .base_offset   (base_offset_reg),
        .draw_value    (draw_value_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .stamp_address (stamp_address),
        .pixel_value   (pixel_value),
        .at_edge       (at_edge),
        .status        (status),
        .last          (last)
    );

endmodule

`default_nettype wire

[rtl/lrsa_front.sv]
// ============================================================================
// Segment classifier
// Turns endpoints into spans, step directions, major axis and a length check.
// ============================================================================
`default_nettype none

module lrsa_front #(
    parameter int MAX_SPAN = lrsa_pkg::MAX_SPAN_DEF
) (
    input  wire logic [lrsa_pkg::COORD_BITS-1:0] start_x,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0] start_y,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0] end_x,
    input  wire logic [lrsa_pkg::COORD_BITS-1:0] end_y,
    output lrsa_pkg::seg_desc_t                  desc
);

    localparam int CW = lrsa_pkg::COORD_BITS;

    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW:0]        adx_w;
    logic [CW:0]        ady_w;
    logic [CW-1:0]      adx;
    logic [CW-1:0]      ady;
    logic               xmajor;
    logic [CW-1:0]      major_full;
    logic [CW-1:0]      minor_full;

    always_comb
    begin
        dx     = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
        dy     = signed'({1'b0, end_y}) - signed'({1'b0, start_y});
        adx_w  = dx[CW] ? unsigned'(-dx) : unsigned'(dx);
        ady_w  = dy[CW] ? unsigned'(-dy) : unsigned'(dy);
        adx    = adx_w[CW-1:0];
        ady    = ady_w[CW-1:0];
        // tie goes to x
        xmajor     = (adx >= ady);
        major_full = xmajor ? adx : ady;
        minor_full = xmajor ? ady : adx;

        desc.sx       = start_x;
        desc.sy       = start_y;
        desc.x_move   = (dx != '0);
        desc.x_dec    = dx[CW];
        desc.y_move   = (dy != '0);
        desc.y_dec    = dy[CW];
        desc.xmajor   = xmajor;
        desc.too_long = (major_full > CW'(MAX_SPAN));
        desc.major    = major_full[lrsa_pkg::SPAN_W-1:0];
        desc.minor    = minor_full[lrsa_pkg::SPAN_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/lrsa_queue.sv]
// ============================================================================
// Segment descriptor queue
// Two-entry FIFO that decouples the classifier from the point stepper.
// ============================================================================
`default_nettype none

module lrsa_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire lrsa_pkg::seg_desc_t push_desc,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output lrsa_pkg::seg_desc_t      head_desc
);

    lrsa_pkg::seg_desc_t                 entry_reg [lrsa_pkg::QDEPTH];
    logic [lrsa_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [lrsa_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [lrsa_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [lrsa_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [lrsa_pkg::QCNT_W-1:0]         count_reg;
    logic [lrsa_pkg::QCNT_W-1:0]         count_next;

    assign full      = (count_reg == lrsa_pkg::QCNT_W'(lrsa_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

[rtl/lrsa_back.sv]
// ============================================================================
// Point stepper and stamp address pipeline
// Walks one segment a point per cycle unless the output stalls, then forms the stamp address.
// ============================================================================
`default_nettype none

module lrsa_back #(
    parameter int BRUSH_SIZE = lrsa_pkg::BRUSH_SIZE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_not_empty,
    input  wire lrsa_pkg::seg_desc_t                q_desc,
    output logic                                    q_pop,
    input  wire logic [lrsa_pkg::ROW_W-1:0]         row_width,
    input  wire logic [lrsa_pkg::BASE_W-1:0]        base_offset,
    input  wire logic [lrsa_pkg::PIX_W-1:0]         draw_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [lrsa_pkg::COORD_BITS-1:0]         point_x,
    output logic [lrsa_pkg::COORD_BITS-1:0]         point_y,
    output logic [lrsa_pkg::ADDR_W-1:0]             stamp_address,
    output logic [lrsa_pkg::PIX_W-1:0]              pixel_value,
    output logic                                    at_edge,
    output logic                                    status,
    output logic                                    last
);

    localparam int CW  = lrsa_pkg::COORD_BITS;
    localparam int SW  = lrsa_pkg::SPAN_W;
    localparam int EW  = lrsa_pkg::ERR_W;
    localparam int AW  = lrsa_pkg::ADDR_W;
    localparam logic [CW-1:0] HALF = CW'(BRUSH_SIZE / 2);

    // Stepper state
    lrsa_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]         x_reg, x_next;
    logic [CW-1:0]         y_reg, y_next;
    logic signed [EW-1:0]  err_reg, err_next;
    logic [SW-1:0]         rem_reg, rem_next;
    logic [SW-1:0]         major_reg, major_next;
    logic [SW-1:0]         minor_reg, minor_next;
    logic                  x_move_reg, x_move_next;
    logic                  x_dec_reg, x_dec_next;
    logic                  y_move_reg, y_move_next;
    logic                  y_dec_reg, y_dec_next;
    logic                  xmajor_reg, xmajor_next;
    logic                  too_long_reg, too_long_next;

    // Pipeline stages
    logic                  s1_valid_reg;
    logic [CW-1:0]         s1_x_reg, s1_y_reg, s1_cx_reg;
    logic [AW-1:0]         s1_prod_reg;
    logic                  s1_edge_reg, s1_status_reg, s1_last_reg;
    logic                  out_valid_reg;
    logic [CW-1:0]         point_x_reg, point_y_reg;
    logic [AW-1:0]         stamp_address_reg;
    logic [lrsa_pkg::PIX_W-1:0] pixel_value_reg;
    logic                  at_edge_reg, status_reg, last_reg;

    logic                  adv;
    logic                  emit;
    logic                  emit_last;
    logic signed [EW-1:0]  err_add;
    logic                  step_minor;
    logic [CW-1:0]         x_step, y_step;
    logic                  edge_c;
    logic [CW-1:0]         cx_c, cy_c;
    logic [AW-1:0]         prod_c;
    logic [AW-1:0]         addr_c;

    // Whole pipeline advances when the output slot is free or being taken
    assign adv  = !out_valid_reg || !out_stall;
    assign emit = (state_reg == lrsa_pkg::BK_RUN) && adv;
    assign emit_last = too_long_reg || (rem_reg == '0);

    always_comb
    begin
        err_add    = err_reg + signed'(EW'({minor_reg, 1'b0}));
        step_minor = (err_add >= signed'(EW'(major_reg))) && (minor_reg != '0);
        x_step     = x_dec_reg ? x_reg - 1'b1 : x_reg + 1'b1;
        y_step     = y_dec_reg ? y_reg - 1'b1 : y_reg + 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        q_pop         = 1'b0;
        x_next        = x_reg;
        y_next        = y_reg;
        err_next      = err_reg;
        rem_next      = rem_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        x_move_next   = x_move_reg;
        x_dec_next    = x_dec_reg;
        y_move_next   = y_move_reg;
        y_dec_next    = y_dec_reg;
        xmajor_next   = xmajor_reg;
        too_long_next = too_long_reg;
        unique case (state_reg)
            lrsa_pkg::BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop         = 1'b1;
                    x_next        = q_desc.sx;
                    y_next        = q_desc.sy;
                    err_next      = '0;
                    rem_next      = q_desc.major;
                    major_next    = q_desc.major;
                    minor_next    = q_desc.minor;
                    x_move_next   = q_desc.x_move;
                    x_dec_next    = q_desc.x_dec;
                    y_move_next   = q_desc.y_move;
                    y_dec_next    = q_desc.y_dec;
                    xmajor_next   = q_desc.xmajor;
                    too_long_next = q_desc.too_long;
                    state_next    = lrsa_pkg::BK_RUN;
                end
            end
            lrsa_pkg::BK_RUN:
            begin
                if (adv)
                begin
                    err_next = step_minor ? err_add - signed'(EW'({major_reg, 1'b0}))
                                          : err_add;
                    if (xmajor_reg)
                    begin
                        x_next = x_move_reg ? x_step : x_reg;
                        y_next = (step_minor && y_move_reg) ? y_step : y_reg;
                    end
                    else
                    begin
                        y_next = y_move_reg ? y_step : y_reg;
                        x_next = (step_minor && x_move_reg) ? x_step : x_reg;
                    end
                    rem_next = rem_reg - 1'b1;
                    if (emit_last)
                    begin
                        state_next = lrsa_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lrsa_pkg::BK_IDLE;
            end
        endcase
    end

    // Stage one: saturated stamp corner, edge flag and row product; then the address sum from stage one
    always_comb
    begin
        edge_c = (x_reg < HALF) || (y_reg < HALF);
        cx_c   = (x_reg < HALF) ? '0 : x_reg - HALF;
        cy_c   = (y_reg < HALF) ? '0 : y_reg - HALF;
        prod_c = AW'(row_width) * AW'(cy_c);
        addr_c = AW'(base_offset) + AW'(s1_cx_reg) + s1_prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrsa_pkg::BK_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                s1_valid_reg  <= emit;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        err_reg      <= err_next;
        rem_reg      <= rem_next;
        major_reg    <= major_next;
        minor_reg    <= minor_next;
        x_move_reg   <= x_move_next;
        x_dec_reg    <= x_dec_next;
        y_move_reg   <= y_move_next;
        y_dec_reg    <= y_dec_next;
        xmajor_reg   <= xmajor_next;
        too_long_reg <= too_long_next;
        if (adv)
        begin
            s1_x_reg      <= x_reg;
            s1_y_reg      <= y_reg;
            s1_cx_reg     <= cx_c;
            s1_prod_reg   <= prod_c;
            s1_edge_reg   <= edge_c;
            s1_status_reg <= too_long_reg;
            s1_last_reg   <= emit_last;
            // Error results carry zero payload
            point_x_reg       <= s1_status_reg ? '0 : s1_x_reg;
            point_y_reg       <= s1_status_reg ? '0 : s1_y_reg;
            stamp_address_reg <= s1_status_reg ? '0 : addr_c;
            pixel_value_reg   <= s1_status_reg ? '0 : draw_value;
            at_edge_reg       <= s1_status_reg ? 1'b0 : s1_edge_reg;
            status_reg        <= s1_status_reg;
            last_reg          <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = point_x_reg;
    assign point_y       = point_y_reg;
    assign stamp_address = stamp_address_reg;
    assign pixel_value   = pixel_value_reg;
    assign at_edge       = at_edge_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

[rtl/lrsa_checker.sv]
// ============================================================================
// Line raster stamp addresser checker
// Port-level assertions on the point output, bound to the top level.
// ============================================================================
`default_nettype none

module lrsa_checker #(
    parameter int BRUSH_SIZE = lrsa_pkg::BRUSH_SIZE_DEF
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic [lrsa_pkg::COORD_BITS-1:0]      point_x,
    input wire logic [lrsa_pkg::COORD_BITS-1:0]      point_y,
    input wire logic [lrsa_pkg::ADDR_W-1:0]          stamp_address,
    input wire logic [lrsa_pkg::PIX_W-1:0]           pixel_value,
    input wire logic                                 at_edge,
    input wire logic                                 status,
    input wire logic                                 last
);

    localparam logic [lrsa_pkg::COORD_BITS-1:0] HALF =
        lrsa_pkg::COORD_BITS'(BRUSH_SIZE / 2);

    // A stalled transfer holds its point, stamp address, status and last
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(stamp_address) && $stable(last) && $stable(status))
        else $error("output transfer changed while stalled");

    // A too-long segment closes with its single error transfer
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last)
        else $error("error transfer without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (point_x == '0) && (point_y == '0)
            && (stamp_address == '0) && (pixel_value == '0) && !at_edge)
        else $error("error transfer carries payload");

    a_edge_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> at_edge == ((point_x < HALF) || (point_y < HALF)))
        else $error("edge flag disagrees with point");

endmodule

bind line_raster_stamp_addresser_top lrsa_checker #(
    .BRUSH_SIZE (BRUSH_SIZE)
) u_lrsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .stamp_address (stamp_address),
    .pixel_value   (pixel_value),
    .at_edge       (at_edge),
    .status        (status),
    .last          (last)
);

`default_nettype wire
